### rtl/core/mrf_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU request framer.
package mrf_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FN_READ_HOLD  = 8'h03;
  localparam logic [7:0]  FN_WRITE_MULT = 8'h10;
  localparam logic [7:0]  WR_BYTE_COUNT = 8'h02;
  localparam logic [7:0]  WR_REG_COUNT  = 8'h01;
  localparam logic [7:0]  SLAVE_RESET   = 8'h01;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Frame body (everything ahead of the CRC) is at most nine bytes.
  localparam int BODY_MAX = 9;
  localparam int IDX_W    = 4;
  localparam logic [IDX_W-1:0] BODY_LEN_READ  = 4'd6;
  localparam logic [IDX_W-1:0] BODY_LEN_WRITE = 4'd9;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        kind;
    logic [15:0] reg_address;
    logic [6:0]  register_count;
    logic [15:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } res_t;

  // Classified request as held in the queue.
  typedef struct packed {
    logic [BODY_MAX-1:0][7:0] body;
    logic [IDX_W-1:0]         body_len;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/mrf_front.sv
// Front end: takes a request transaction and lays out its frame body for the queue.
module mrf_front (
  input  logic                 start,
  input  mrf_pkg::req_t        in_req,
  input  logic [7:0]           slave_addr,
  input  mrf_pkg::q_status_t   q_stat,
  output logic                 busy,
  output logic                 push,
  output mrf_pkg::job_t        job
);
  import mrf_pkg::*;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    job.body    = '0;
    job.body[0] = slave_addr;
    job.body[2] = in_req.reg_address[15:8];
    job.body[3] = in_req.reg_address[7:0];
    if (in_req.kind == KIND_WRITE) begin
      job.body[1]  = FN_WRITE_MULT;
      job.body[4]  = 8'h00;
      job.body[5]  = WR_REG_COUNT;
      job.body[6]  = WR_BYTE_COUNT;
      job.body[7]  = in_req.write_value[15:8];
      job.body[8]  = in_req.write_value[7:0];
      job.body_len = BODY_LEN_WRITE;
    end else begin
      job.body[1]  = FN_READ_HOLD;
      job.body[4]  = 8'h00;
      job.body[5]  = {1'b0, in_req.register_count};
      job.body_len = BODY_LEN_READ;
    end
  end

endmodule

### rtl/core/mrf_queue.sv
// Small FIFO of classified requests between the front and back ends.
module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mrf_pkg::job_t      wr_job,
  input  logic               pop,
  output mrf_pkg::job_t      rd_job,
  output mrf_pkg::q_status_t q_stat
);
  import mrf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

### rtl/core/mrf_back.sv
// Back end: shifts out one frame byte per cycle, folding each body byte into the CRC.
module mrf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mrf_pkg::q_status_t q_stat,
  input  mrf_pkg::job_t      q_job,
  output logic               pop,
  output logic               out_strobe,
  output mrf_pkg::res_t      out_res
);
  import mrf_pkg::*;

  job_t             job_r, job_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             active_r, active_nxt;
  logic             strobe_r;
  res_t             res_r, res_nxt;
  logic             in_body, crc_lo, frame_end;
  logic [7:0]       cur_byte;

  always_comb begin
    in_body   = (idx_r < job_r.body_len);
    crc_lo    = (idx_r == job_r.body_len);
    frame_end = active_r && !in_body && !crc_lo;
    if (in_body) begin
      cur_byte = job_r.body[idx_r];
    end else if (crc_lo) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = crc_r[15:8];
    end
    res_nxt.tx_byte   = cur_byte;
    res_nxt.last_byte = frame_end;
  end

  // Next frame is loaded on the cycle of the previous CRC high byte, so frames run gap-free.
  always_comb begin
    pop        = (!active_r || frame_end) && !q_stat.empty;
    job_nxt    = job_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    active_nxt = active_r;
    if (pop) begin
      job_nxt    = q_job;
      idx_nxt    = '0;
      crc_nxt    = CRC_INIT;
      active_nxt = 1'b1;
    end else if (frame_end) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt = idx_r + 1'b1;
      if (in_body) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    crc_r <= crc_nxt;
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

### rtl/core/modbus_rtu_request_framer_core.sv
// Modbus RTU request framer top level: config register, front end, request queue, back end.
//
// A request is taken when start is high and busy is low; busy rises only when the request
// queue (QUEUE_DEPTH entries) is full. The back end emits one frame byte per clock on
// out_strobe, so a read frame is 8 bytes long and a write frame 11. The byte sequencer
// also folds each body byte into the CRC in the same cycle. Consecutive frames follow
// back to back. When the block is idle, an accepted request is written into the queue,
// then loaded into the back end's job register, and its first byte is strobed from the
// output register. Results are not flow-controlled: the receiver must take every byte in
// the cycle it is strobed. The slave address is sampled when a request is taken.
module modbus_rtu_request_framer_core #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mrf_pkg::req_t      in_req,
  output logic               out_strobe,
  output mrf_pkg::res_t      out_res,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import mrf_pkg::*;

  logic [7:0] slave_r;
  logic       push, pop;
  job_t       fe_job, q_job;
  q_status_t  q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r <= SLAVE_RESET;
    end else if (cfg_we) begin
      slave_r <= cfg_wdata;
    end
  end

  mrf_front u_front (
    .start      (start),
    .in_req     (in_req),
    .slave_addr (slave_r),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .job        (fe_job)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (fe_job),
    .pop    (pop),
    .rd_job (q_job),
    .q_stat (q_stat)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_job      (q_job),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  a_q_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !q_stat.empty)
    else $error("accepted transaction did not reach the queue");

  a_last_not_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.last_byte) |-> $past(out_strobe))
    else $error("frame end strobed without a preceding byte");

endmodule

### tb/tb.sv
// Self-checking testbench for the Modbus RTU request framer core.
module tb;
  import mrf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // Expected frame bytes, worked out for each accepted request.
  class frame_scoreboard;
    res_t frame_bytes[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return frame_bytes.size();
    endfunction

    // Build the whole RTU frame for one request and queue its bytes.
    function void frame_request(req_t r, logic [7:0] slave);
      logic [7:0] body[$];
      logic [15:0] crc;
      res_t b;
      body.push_back(slave);
      body.push_back(r.kind == KIND_WRITE ? FN_WRITE_MULT : FN_READ_HOLD);
      body.push_back(r.reg_address[15:8]);
      body.push_back(r.reg_address[7:0]);
      if (r.kind == KIND_WRITE) begin
        body.push_back(8'h00);
        body.push_back(WR_REG_COUNT);
        body.push_back(WR_BYTE_COUNT);
        body.push_back(r.write_value[15:8]);
        body.push_back(r.write_value[7:0]);
      end else begin
        body.push_back(8'h00);
        body.push_back({1'b0, r.register_count});
      end
      crc = CRC_INIT;
      foreach (body[i]) begin
        crc ^= {8'h00, body[i]};
        for (int k = 0; k < 8; k++) begin
          if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
          else crc = crc >> 1;
        end
      end
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      foreach (body[i]) begin
        b.tx_byte = body[i];
        b.last_byte = (i == body.size() - 1);
        frame_bytes.push_back(b);
      end
    endfunction

    function void check_byte(res_t got);
      res_t want;
      if (frame_bytes.size() == 0) begin
        $error("unexpected frame byte: tx_byte %h last_byte %b", got.tx_byte, got.last_byte);
        errors++;
        return;
      end
      want = frame_bytes.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %h, actual %h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %b, actual %b", want.last_byte, got.last_byte);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_strobe;
  res_t out_res;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  logic [7:0] slave_addr;
  int cycles;
  frame_scoreboard sb = new();

  modbus_rtu_request_framer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_byte(out_res);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("modbus_rtu_request_framer_core regression: fail");
      $finish;
    end
  end

  function automatic req_t make_req(logic kind, logic [15:0] addr, logic [6:0] count,
                                    logic [15:0] value);
    req_t r;
    r.kind = kind;
    r.reg_address = addr;
    r.register_count = count;
    r.write_value = value;
    return r;
  endfunction

  function automatic req_t random_req();
    logic [6:0] count;
    // mostly legal counts, now and then the out-of-range ones
    if ($urandom_range(0, 9) == 0) count = 7'($urandom);
    else count = 7'($urandom_range(1, 125));
    return make_req(1'($urandom_range(0, 1)), 16'($urandom), count, 16'($urandom));
  endfunction

  // Hold the request on the port until the framer accepts it (busy low at a clock edge).
  task automatic send_request(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sb.frame_request(r, slave_addr);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending and let every outstanding frame drain out.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_slave(input logic [7:0] v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    slave_addr = v;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    slave_addr = SLAVE_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, odd counts, garbage in unused fields
    send_request(make_req(KIND_READ, 16'h0000, 7'd1, 16'($urandom)));
    send_request(make_req(KIND_READ, 16'hFFFF, 7'd125, 16'($urandom)));
    send_request(make_req(KIND_READ, 16'h1234, 7'd0, 16'hFFFF));
    send_request(make_req(KIND_READ, 16'hABCD, 7'd126, 16'h0000));
    send_request(make_req(KIND_READ, 16'h5555, 7'd127, 16'($urandom)));
    send_request(make_req(KIND_WRITE, 16'h0000, 7'($urandom), 16'h0000));
    send_request(make_req(KIND_WRITE, 16'hFFFF, 7'd127, 16'hFFFF));
    send_request(make_req(KIND_WRITE, 16'hAAAA, 7'd0, 16'h5555));
    hold_off(3);
    send_request(make_req(KIND_WRITE, 16'h0102, 7'd64, 16'h8001));
    send_request(make_req(KIND_READ, 16'h8000, 7'd64, 16'h7FFE));

    write_slave(8'h00);
    send_request(make_req(KIND_READ, 16'hFFFF, 7'd125, 16'h0000));
    send_request(make_req(KIND_WRITE, 16'h0000, 7'd1, 16'hFFFF));
    write_slave(8'hFF);
    send_request(make_req(KIND_WRITE, 16'hFFFF, 7'd1, 16'h0000));
    send_request(make_req(KIND_READ, 16'h0000, 7'd1, 16'hFFFF));
    send_request(make_req(KIND_READ, 16'h7FFF, 7'h55, 16'h1234));
    write_slave(8'hA5);
    send_request(make_req(KIND_WRITE, 16'h5A5A, 7'h2A, 16'hA5A5));
    send_request(make_req(KIND_READ, 16'hC3C3, 7'h7F, 16'h3C3C));

    // random phases, each under a fresh slave address; the last one without gaps
    for (int phase = 0; phase < 4; phase++) begin
      write_slave(8'($urandom));
      for (int n = 0; n < 120; n++) begin
        send_request(random_req());
        if (phase < 3 && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 18));
        // sender waits for the line to go quiet mid-phase
        if (phase == 1 && n == 60) settle();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d frame bytes never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("modbus_rtu_request_framer_core regression: pass");
    end else begin
      $display("modbus_rtu_request_framer_core regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_queue.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer_core.sv
tb/tb.sv
